// ===== hw/rtl/evt_pkg.sv =====
`default_nettype none

package evt_pkg;

   // Field widths fixed by the event record and the result record.
   localparam int TYPE_W   = 16;
   localparam int CODE_W   = 16;
   localparam int VALUE_W  = 32;
   localparam int SCREEN_W = 16;
   localparam int PROD_W   = VALUE_W + SCREEN_W;
   localparam int CSR_IDX_W = 3;

   // Serial multiply and divide step counts.
   localparam int MUL_STEPS = SCREEN_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   // Event classes.
   localparam logic [TYPE_W-1:0] EV_SYN = 16'd0;
   localparam logic [TYPE_W-1:0] EV_KEY = 16'd1;
   localparam logic [TYPE_W-1:0] EV_REL = 16'd2;
   localparam logic [TYPE_W-1:0] EV_ABS = 16'd3;

   // Codes within the classes.
   localparam logic [CODE_W-1:0] CODE_SYNC  = 16'd0;
   localparam logic [CODE_W-1:0] AXIS_X     = 16'd0;
   localparam logic [CODE_W-1:0] AXIS_Y     = 16'd1;
   localparam logic [CODE_W-1:0] CODE_WHEEL = 16'd8;
   localparam logic [CODE_W-1:0] BTN_FIRST  = 16'h0110;
   localparam logic [CODE_W-1:0] BTN_LAST   = 16'h0114;
   localparam logic [CODE_W-1:0] KEY_FIRST  = 16'd1;
   localparam logic [CODE_W-1:0] KEY_LAST   = 16'd88;
   localparam logic [CODE_W-1:0] EXT_FIRST  = 16'd96;
   localparam logic [CODE_W-1:0] EXT_END    = 16'd128;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ABS_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_MAX_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_MAX_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_W   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_H   = 3'd4;

   localparam logic [SCREEN_W-1:0] SCREEN_W_RESET = 16'd1920;
   localparam logic [SCREEN_W-1:0] SCREEN_H_RESET = 16'd1080;

   localparam logic RESULT_KEY   = 1'b0;
   localparam logic RESULT_MOUSE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCALE
   } state_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_MUL,
      SC_DIV
   } scale_phase_type;

   // Extended key table for codes 96..127; zero means no scancode.
   function automatic logic [7:0] ext_scancode(input logic [4:0] idx);
      logic [7:0] sc;
      unique case (idx)
         5'd0:  sc = 8'h1C;
         5'd1:  sc = 8'h1D;
         5'd2:  sc = 8'h35;
         5'd3:  sc = 8'h37;
         5'd4:  sc = 8'h38;
         5'd6:  sc = 8'h47;
         5'd7:  sc = 8'h48;
         5'd8:  sc = 8'h49;
         5'd9:  sc = 8'h4B;
         5'd10: sc = 8'h4D;
         5'd11: sc = 8'h4F;
         5'd12: sc = 8'h50;
         5'd13: sc = 8'h51;
         5'd14: sc = 8'h52;
         5'd15: sc = 8'h53;
         5'd29: sc = 8'h5B;
         5'd30: sc = 8'h5C;
         5'd31: sc = 8'h5D;
         default: sc = 8'h00;
      endcase
      return sc;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/evt_scale_unit.sv =====
`default_nettype none

module evt_scale_unit
   import evt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [VALUE_W-1:0]  value,
   input  wire logic [SCREEN_W-1:0] screen,
   input  wire logic [VALUE_W-1:0]  amax,
   output logic                     done,
   output logic [VALUE_W-1:0]       scaled
);

   scale_phase_type         phase_ff, phase_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [SCREEN_W-1:0]     mult_ff, mult_in;
   logic [VALUE_W-1:0]      mcand_ff, mcand_in;
   logic [VALUE_W-1:0]      div_ff, div_in;
   logic [VALUE_W-1:0]      rem_ff, rem_in;

   logic [VALUE_W:0]        rem_shift;
   logic [VALUE_W:0]        rem_diff;
   logic                    rem_ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SC_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mult_ff  <= mult_in;
      mcand_ff <= mcand_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   // One restoring-division step: the next dividend bit enters the remainder
   // and the quotient bit shifts into the vacated low end of the product.
   assign rem_shift = {rem_ff, prod_ff[PROD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign rem_ge    = !rem_diff[VALUE_W];

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      prod_in  = prod_ff;
      mult_in  = mult_ff;
      mcand_in = mcand_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      unique case (phase_ff)
         SC_IDLE: begin
            if (start) begin
               if (amax == '0) begin
                  prod_in = {{SCREEN_W{1'b0}}, value};
                  done_in = 1'b1;
               end else begin
                  prod_in  = '0;
                  mult_in  = screen;
                  mcand_in = value;
                  div_in   = amax;
                  rem_in   = '0;
                  cnt_in   = '0;
                  phase_in = SC_MUL;
               end
            end
         end
         SC_MUL: begin
            prod_in = {prod_ff[PROD_W-2:0], 1'b0}
                    + (mult_ff[SCREEN_W-1] ? {{SCREEN_W{1'b0}}, mcand_ff} : {PROD_W{1'b0}});
            mult_in = {mult_ff[SCREEN_W-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               phase_in = SC_DIV;
            end
         end
         SC_DIV: begin
            rem_in  = rem_ge ? rem_diff[VALUE_W-1:0] : rem_shift[VALUE_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], rem_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               phase_in = SC_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = SC_IDLE;
         end
      endcase
   end

   assign done   = done_ff;
   assign scaled = prod_ff[VALUE_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/evdev_event_translator.sv =====
`default_nettype none

// Input-event translator. Each beat on the req_ channel carries one
// {type, code, value} record; each beat on the rsp_ channel carries either a
// keyboard scancode or one accumulated mouse event. Key, button, relative and
// sync records are decoded in the ST_DECODE state after acceptance; a result
// goes through the result register before it is offered, and decoding waits
// while that register is full. The next record is taken back in ST_IDLE. An
// absolute X or Y record is scaled by screen size over axis maximum in a
// bit-serial unit: sixteen shift-and-add multiply steps, one per bit of the
// screen size, then forty-eight restoring-division steps, one per quotient
// bit, and no scaling is done when the axis maximum is zero. One record is
// handled at a time. The result register lets a new record be taken while an
// earlier result still waits for rsp_ready. Configuration is written
// through the csr_ channel, which is always ready; writes to unused
// indexes are dropped.

module evdev_event_translator
   import evt_pkg::*;
#(
   parameter int ACCUM_WIDTH = 32
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [TYPE_W-1:0]     req_event_type,
   input  wire logic [CODE_W-1:0]     req_event_code,
   input  wire logic [VALUE_W-1:0]    req_event_value,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_result_kind,
   output logic [7:0]                 rsp_scancode,
   output logic                       rsp_key_pressed,
   output logic                       rsp_extended_key,
   output logic signed [15:0]         rsp_move_x,
   output logic signed [15:0]         rsp_move_y,
   output logic signed [7:0]          rsp_wheel_move,
   output logic [4:0]                 rsp_button_bits,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]           csr_data
);

   // Configuration registers.
   logic                  abs_mode_ff;
   logic [VALUE_W-1:0]    axis_max_x_ff;
   logic [VALUE_W-1:0]    axis_max_y_ff;
   logic [SCREEN_W-1:0]   screen_w_ff;
   logic [SCREEN_W-1:0]   screen_h_ff;

   // Sequencer and the record being worked on.
   state_type             state_ff, state_in;
   logic [TYPE_W-1:0]     type_ff;
   logic [CODE_W-1:0]     code_ff;
   logic [VALUE_W-1:0]    value_ff;

   // Pointer state.
   logic [ACCUM_WIDTH-1:0] sum_x_ff, sum_x_in;
   logic [ACCUM_WIDTH-1:0] sum_y_ff, sum_y_in;
   logic [ACCUM_WIDTH-1:0] sum_w_ff, sum_w_in;
   logic [4:0]             held_ff, held_in;
   logic                   pending_ff, pending_in;
   logic [VALUE_W-1:0]     prev_x_ff, prev_x_in;
   logic [VALUE_W-1:0]     prev_y_ff, prev_y_in;
   logic                   origin_ff, origin_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   load_rsp;
   logic                   kind_ff, kind_in;
   logic [7:0]             scan_ff, scan_in;
   logic                   pressed_ff, pressed_in;
   logic                   ext_ff, ext_in;
   logic [15:0]            mx_ff, mx_in;
   logic [15:0]            my_ff, my_in;
   logic [7:0]             mw_ff, mw_in;
   logic [4:0]             btn_ff, btn_in;

   // Decode helpers.
   logic                   out_free;
   logic                   pressed;
   logic [7:0]             ext_sc;
   logic [63:0]            value_sext;
   logic [63:0]            diff_sext;
   logic [VALUE_W-1:0]     diff;
   logic [4:0]             btn_mask;
   logic [CODE_W-1:0]      btn_offset;

   // Scaling unit connection.
   logic                   scale_start;
   logic [SCREEN_W-1:0]    scale_screen;
   logic [VALUE_W-1:0]     scale_amax;
   logic                   scale_done;
   logic [VALUE_W-1:0]     scale_result;

   evt_scale_unit u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .value  (value_ff),
      .screen (scale_screen),
      .amax   (scale_amax),
      .done   (scale_done),
      .scaled (scale_result)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // The result register can take a new beat when empty or when its current
   // beat leaves in this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign pressed    = (value_ff != '0);
   assign ext_sc     = ext_scancode(code_ff[4:0]);
   assign value_sext = {{32{value_ff[VALUE_W-1]}}, value_ff};
   assign btn_offset = code_ff - BTN_FIRST;
   assign btn_mask   = 5'd1 << btn_offset[2:0];

   // X records use the width and X maximum; Y records the height and Y maximum.
   assign scale_screen = code_ff[0] ? screen_h_ff : screen_w_ff;
   assign scale_amax   = code_ff[0] ? axis_max_y_ff : axis_max_x_ff;
   assign diff         = scale_result - (code_ff[0] ? prev_y_ff : prev_x_ff);
   assign diff_sext    = {{32{diff[VALUE_W-1]}}, diff};

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_mode_ff   <= 1'b0;
         axis_max_x_ff <= '0;
         axis_max_y_ff <= '0;
         screen_w_ff   <= SCREEN_W_RESET;
         screen_h_ff   <= SCREEN_H_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ABS_MODE:   abs_mode_ff   <= csr_data[0];
            CSR_AXIS_MAX_X: axis_max_x_ff <= csr_data;
            CSR_AXIS_MAX_Y: axis_max_y_ff <= csr_data;
            CSR_SCREEN_W:   screen_w_ff   <= csr_data[SCREEN_W-1:0];
            CSR_SCREEN_H:   screen_h_ff   <= csr_data[SCREEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_w_ff     <= '0;
         held_ff      <= '0;
         pending_ff   <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         origin_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_w_ff     <= sum_w_in;
         held_ff      <= held_in;
         pending_ff   <= pending_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         origin_ff    <= origin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The accepted record is held for the whole time it is worked on.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff  <= req_event_type;
         code_ff  <= req_event_code;
         value_ff <= req_event_value;
      end
      if (load_rsp) begin
         kind_ff    <= kind_in;
         scan_ff    <= scan_in;
         pressed_ff <= pressed_in;
         ext_ff     <= ext_in;
         mx_ff      <= mx_in;
         my_ff      <= my_in;
         mw_ff      <= mw_in;
         btn_ff     <= btn_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      sum_w_in    = sum_w_ff;
      held_in     = held_ff;
      pending_in  = pending_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      origin_in   = origin_ff;
      scale_start = 1'b0;
      load_rsp    = 1'b0;
      kind_in     = RESULT_KEY;
      scan_in     = '0;
      pressed_in  = 1'b0;
      ext_in      = 1'b0;
      mx_in       = '0;
      my_in       = '0;
      mw_in       = '0;
      btn_in      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_IDLE;
            priority if (type_ff == EV_KEY) begin
               priority if (code_ff >= BTN_FIRST && code_ff <= BTN_LAST) begin
                  held_in    = pressed ? (held_ff | btn_mask) : (held_ff & ~btn_mask);
                  pending_in = 1'b1;
               end else if (code_ff >= KEY_FIRST && code_ff <= KEY_LAST) begin
                  // A result-producing record waits here until the result
                  // register can take it.
                  if (out_free) begin
                     load_rsp   = 1'b1;
                     scan_in    = code_ff[7:0];
                     pressed_in = pressed;
                  end else begin
                     state_in = ST_DECODE;
                  end
               end else if (code_ff >= EXT_FIRST && code_ff < EXT_END && ext_sc != '0) begin
                  if (out_free) begin
                     load_rsp   = 1'b1;
                     scan_in    = ext_sc;
                     pressed_in = pressed;
                     ext_in     = 1'b1;
                  end else begin
                     state_in = ST_DECODE;
                  end
               end else begin
               end
            end else if (type_ff == EV_REL) begin
               priority if (code_ff == AXIS_X) begin
                  sum_x_in   = sum_x_ff + value_sext[ACCUM_WIDTH-1:0];
                  pending_in = 1'b1;
               end else if (code_ff == AXIS_Y) begin
                  sum_y_in   = sum_y_ff + value_sext[ACCUM_WIDTH-1:0];
                  pending_in = 1'b1;
               end else if (code_ff == CODE_WHEEL) begin
                  sum_w_in   = sum_w_ff - value_sext[ACCUM_WIDTH-1:0];
                  pending_in = 1'b1;
               end else begin
               end
            end else if (type_ff == EV_ABS) begin
               if (code_ff == AXIS_X || code_ff == AXIS_Y) begin
                  scale_start = 1'b1;
                  state_in    = ST_SCALE;
               end
            end else if (type_ff == EV_SYN && code_ff == CODE_SYNC) begin
               if (pending_ff) begin
                  if (out_free) begin
                     load_rsp   = 1'b1;
                     kind_in    = RESULT_MOUSE;
                     mx_in      = sum_x_ff[15:0];
                     my_in      = sum_y_ff[15:0];
                     mw_in      = sum_w_ff[7:0];
                     btn_in     = held_ff;
                     sum_x_in   = '0;
                     sum_y_in   = '0;
                     sum_w_in   = '0;
                     pending_in = 1'b0;
                     origin_in  = abs_mode_ff;
                  end else begin
                     state_in = ST_DECODE;
                  end
               end else begin
                  origin_in = abs_mode_ff;
               end
            end else begin
            end
         end

         ST_SCALE: begin
            // A position only sets the origin until a sync record arrives with absolute mode on.
            if (scale_done) begin
               state_in = ST_IDLE;
               if (code_ff[0]) begin
                  prev_y_in = scale_result;
                  if (origin_ff) begin
                     sum_y_in   = sum_y_ff + diff_sext[ACCUM_WIDTH-1:0];
                     pending_in = 1'b1;
                  end
               end else begin
                  prev_x_in = scale_result;
                  if (origin_ff) begin
                     sum_x_in   = sum_x_ff + diff_sext[ACCUM_WIDTH-1:0];
                     pending_in = 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_scancode     = scan_ff;
   assign rsp_key_pressed  = pressed_ff;
   assign rsp_extended_key = ext_ff;
   assign rsp_move_x       = mx_ff;
   assign rsp_move_y       = my_ff;
   assign rsp_wheel_move   = mw_ff;
   assign rsp_button_bits  = btn_ff;

endmodule

`default_nettype wire
